FILE: rtl/core/bool_expr_token_lexer_unit_defines.svh
// Assertion macros shared by the lexer RTL.
`ifndef BOOL_EXPR_TOKEN_LEXER_UNIT_DEFINES_SVH
`define BOOL_EXPR_TOKEN_LEXER_UNIT_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define BETL_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition that, when true, forces a property in the next cycle.
`define BETL_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

FILE: rtl/core/betl_pkg.sv
// Shared types and constants of the boolean expression token lexer.
`timescale 1ns / 1ps

package betl_pkg;

    localparam int MAX_TEXT_DEFAULT = 4096;
    localparam int MAX_RESULTS      = 3;
    localparam int QUEUE_DEPTH      = 4;
    localparam int START_W          = 12;
    localparam int LENGTH_W         = 13;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LESS   = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    typedef enum logic [3:0] {
        KIND_END      = 4'd0,
        KIND_LPAREN   = 4'd1,
        KIND_RPAREN   = 4'd2,
        KIND_BOOLLIT  = 4'd3,
        KIND_ERROR    = 4'd4,
        KIND_NOT      = 4'd5,
        KIND_AND      = 4'd6,
        KIND_OR       = 4'd7,
        KIND_XOR      = 4'd8,
        KIND_NAND     = 4'd9,
        KIND_NOR      = 4'd10,
        KIND_XNOR     = 4'd11,
        KIND_IMPLYR   = 4'd12,
        KIND_IMPLYL   = 4'd13,
        KIND_IDENT    = 4'd14
    } kind_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       byte_valid;
        logic       end_of_text;
    } item_t;

    typedef struct packed {
        kind_t                token_kind;
        logic [START_W-1:0]   token_start;
        logic [LENGTH_W-1:0]  token_length;
        logic                 literal_value;
        logic                 error_to_end;
        logic                 last_of_run;
    } token_t;

endpackage

FILE: rtl/core/bool_expr_token_lexer_unit.sv
// Streaming lexer for boolean expression text, one byte per input beat.
`timescale 1ns / 1ps
`include "bool_expr_token_lexer_unit_defines.svh"

// The lexer takes one character per input beat and returns tokens with their kind, start
// position and length, one token per output beat. All lexing of a beat is done in the cycle
// that accepts it, and its tokens (up to three) go into a four-entry token queue. An item
// is taken only while the queue holds at most one entry; otherwise item_stall is raised
// until the queue has drained to one entry, whatever the item yields. The dialect register
// is written through cfg_wr_en and cfg_wr_data; the user must write it only while the lexer
// is idle, as the block itself does not enforce this. Positions saturate at MAX_TEXT.
module bool_expr_token_lexer_unit #(
    parameter int MAX_TEXT = betl_pkg::MAX_TEXT_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic            cfg_wr_data,
    input  logic            item_valid,
    output logic            item_stall,
    input  betl_pkg::item_t item,
    output logic            token_valid,
    input  logic            token_stall,
    output betl_pkg::token_t token
);

    localparam int POS_W   = $clog2(MAX_TEXT + 1);
    localparam int BEG_W   = $clog2(MAX_TEXT);
    localparam int PTR_W   = $clog2(betl_pkg::QUEUE_DEPTH);
    localparam int COUNT_W = $clog2(betl_pkg::QUEUE_DEPTH + 1);
    localparam int NCAND   = 4;

    typedef enum logic [2:0] {
        M_IDLE,
        M_BANG,
        M_MINUS,
        M_LESS,
        M_IDENT,
        M_BRACE,
        M_STICKY
    } mode_t;

    mode_t              mode_reg, mode_next, mode_mid;
    logic [POS_W-1:0]   text_position_reg, text_position_next, text_position_mid;
    logic [BEG_W-1:0]   tok_begin_reg, tok_begin_next, tok_begin_mid;
    logic [3:0]         word_match_reg, word_match_next, word_match_mid;
    logic [POS_W-1:0]   word_length_reg, word_length_next, word_length_mid;
    logic               dialect_reg;

    betl_pkg::token_t   queue_mem [betl_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    betl_pkg::token_t   cand [NCAND];
    logic [NCAND-1:0]   cand_valid;
    logic [PTR_W-1:0]   cand_idx [NCAND];
    logic [COUNT_W-1:0] wr_offset;
    logic               later_valid;
    logic               run_idle;
    logic               give_end;
    logic [BEG_W-1:0]   clamp_pos;
    logic [POS_W-1:0]   brace_end;
    logic [1:0]         lit_code;
    logic [7:0]         ch;
    logic               accept;
    logic               pop;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]})
            || (c == betl_pkg::CH_UNDER);
    endfunction

    function automatic logic [2:0] cand_len(input logic [1:0] k);
        logic [2:0] len;
        case (k)
            2'd0:    len = 3'd4;
            2'd1:    len = 3'd5;
            default: len = 3'd1;
        endcase
        return len;
    endfunction

    // Letters of the candidate words "true", "false", "1" and "0".
    function automatic logic [7:0] cand_char(input logic [1:0] k, input logic [2:0] i);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            2'd0:
            begin
                case (i)
                    3'd0:    c = 8'h74;
                    3'd1:    c = 8'h72;
                    3'd2:    c = 8'h75;
                    3'd3:    c = 8'h65;
                    default: c = 8'h00;
                endcase
            end
            2'd1:
            begin
                case (i)
                    3'd0:    c = 8'h66;
                    3'd1:    c = 8'h61;
                    3'd2:    c = 8'h6C;
                    3'd3:    c = 8'h73;
                    3'd4:    c = 8'h65;
                    default: c = 8'h00;
                endcase
            end
            2'd2:    c = 8'h31;
            default: c = 8'h30;
        endcase
        return c;
    endfunction

    function automatic logic [3:0] match_step(input logic [3:0] m, input logic [POS_W-1:0] len,
                                              input logic [7:0] c);
        logic [3:0] r;
        for (int k = 0; k < 4; k++)
        begin
            r[k] = m[k] && (len < POS_W'(cand_len(2'(k))))
                && (cand_char(2'(k), len[2:0]) == c);
        end
        return r;
    endfunction

    // Zero for no match, one for a false literal, two for a true literal.
    function automatic logic [1:0] match_final(input logic [3:0] m, input logic [POS_W-1:0] len,
                                               input logic [3:0] allowed);
        logic [1:0] r;
        r = 2'd0;
        for (int k = 3; k >= 0; k--)
        begin
            if (m[k] && allowed[k] && (len == POS_W'(cand_len(2'(k)))))
            begin
                r = (k == 0 || k == 2) ? 2'd2 : 2'd1;
            end
        end
        return r;
    endfunction

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] x);
        return (x < POS_W'(MAX_TEXT)) ? POS_W'(x + 1'b1) : x;
    endfunction

    function automatic betl_pkg::token_t make_token(input betl_pkg::kind_t kind,
                                                    input logic [BEG_W-1:0] start,
                                                    input logic [POS_W-1:0] len,
                                                    input logic val, input logic to_end);
        betl_pkg::token_t t;
        t.token_kind    = kind;
        t.token_start   = betl_pkg::START_W'(start);
        t.token_length  = betl_pkg::LENGTH_W'(len);
        t.literal_value = val;
        t.error_to_end  = to_end;
        t.last_of_run   = 1'b0;
        return t;
    endfunction

    function automatic betl_pkg::token_t flush_ident(input logic [BEG_W-1:0] start,
                                                     input logic [POS_W-1:0] stop,
                                                     input logic [3:0] m,
                                                     input logic [POS_W-1:0] len,
                                                     input logic dia);
        logic [1:0]       code;
        logic [POS_W-1:0] span;
        code = dia ? match_final(m, len, 4'h3) : 2'd0;
        span = POS_W'(stop - POS_W'(start));
        if (code != 2'd0)
        begin
            return make_token(betl_pkg::KIND_BOOLLIT, start, span, code[1], 1'b0);
        end
        return make_token(betl_pkg::KIND_IDENT, start, span, 1'b0, 1'b0);
    endfunction

    assign ch          = item.char_byte;
    assign item_stall  = count_reg > COUNT_W'(betl_pkg::QUEUE_DEPTH - betl_pkg::MAX_RESULTS);
    assign accept      = item_valid && !item_stall;
    assign token_valid = count_reg != '0;
    assign token       = queue_mem[rd_ptr_reg];
    assign pop         = token_valid && !token_stall;

    always_comb
    begin
        clamp_pos = (text_position_reg < POS_W'(MAX_TEXT)) ? BEG_W'(text_position_reg)
                                                         : BEG_W'(MAX_TEXT - 1);
        brace_end = sat_inc(text_position_reg);
        lit_code  = match_final(word_match_reg, word_length_reg, 4'hF);
        for (int i = 0; i < NCAND; i++)
        begin
            cand[i] = make_token(betl_pkg::KIND_END, '0, '0, 1'b0, 1'b0);
        end
        cand_valid        = '0;
        mode_mid          = mode_reg;
        text_position_mid = text_position_reg;
        tok_begin_mid     = tok_begin_reg;
        word_match_mid    = word_match_reg;
        word_length_mid   = word_length_reg;
        run_idle          = 1'b0;
        give_end          = 1'b1;

        if (item.byte_valid)
        begin
            case (mode_reg)
                M_BANG:
                begin
                    mode_mid      = M_IDLE;
                    cand_valid[0] = 1'b1;
                    if (ch == betl_pkg::CH_AMP)
                    begin
                        cand[0] = make_token(betl_pkg::KIND_NAND, tok_begin_reg, POS_W'(2),
                                             1'b0, 1'b0);
                    end
                    else if (ch == betl_pkg::CH_PIPE)
                    begin
                        cand[0] = make_token(betl_pkg::KIND_NOR, tok_begin_reg, POS_W'(2),
                                             1'b0, 1'b0);
                    end
                    else if (ch == betl_pkg::CH_CARET)
                    begin
                        cand[0] = make_token(betl_pkg::KIND_XNOR, tok_begin_reg, POS_W'(2),
                                             1'b0, 1'b0);
                    end
                    else
                    begin
                        cand[0] = make_token(betl_pkg::KIND_NOT, tok_begin_reg, POS_W'(1),
                                             1'b0, 1'b0);
                        run_idle = 1'b1;
                    end
                end
                M_MINUS:
                begin
                    mode_mid      = M_IDLE;
                    cand_valid[0] = 1'b1;
                    if (ch == betl_pkg::CH_GT)
                    begin
                        cand[0] = make_token(betl_pkg::KIND_IMPLYR, tok_begin_reg, POS_W'(2),
                                             1'b0, 1'b0);
                    end
                    else
                    begin
                        cand[0] = make_token(betl_pkg::KIND_ERROR, tok_begin_reg, POS_W'(1),
                                             1'b0, 1'b0);
                        run_idle = 1'b1;
                    end
                end
                M_LESS:
                begin
                    mode_mid      = M_IDLE;
                    cand_valid[0] = 1'b1;
                    if (ch == betl_pkg::CH_MINUS)
                    begin
                        cand[0] = make_token(betl_pkg::KIND_IMPLYL, tok_begin_reg, POS_W'(2),
                                             1'b0, 1'b0);
                    end
                    else
                    begin
                        cand[0] = make_token(betl_pkg::KIND_ERROR, tok_begin_reg, POS_W'(1),
                                             1'b0, 1'b0);
                        run_idle = 1'b1;
                    end
                end
                M_IDENT:
                begin
                    if (is_word(ch))
                    begin
                        word_match_mid  = match_step(word_match_reg, word_length_reg, ch);
                        word_length_mid = sat_inc(word_length_reg);
                    end
                    else
                    begin
                        cand[0]       = flush_ident(tok_begin_reg, text_position_reg,
                                                    word_match_reg, word_length_reg, dialect_reg);
                        cand_valid[0] = 1'b1;
                        mode_mid      = M_IDLE;
                        run_idle      = 1'b1;
                    end
                end
                M_BRACE:
                begin
                    if (ch == betl_pkg::CH_RBRACE)
                    begin
                        cand_valid[0] = 1'b1;
                        mode_mid      = M_IDLE;
                        if (lit_code != 2'd0)
                        begin
                            cand[0] = make_token(betl_pkg::KIND_BOOLLIT, tok_begin_reg,
                                                 POS_W'(brace_end - POS_W'(tok_begin_reg)),
                                                 lit_code[1], 1'b0);
                        end
                        else
                        begin
                            cand[0] = make_token(betl_pkg::KIND_ERROR, tok_begin_reg,
                                                 POS_W'(brace_end - POS_W'(tok_begin_reg)),
                                                 1'b0, 1'b0);
                        end
                    end
                    else
                    begin
                        word_match_mid  = match_step(word_match_reg, word_length_reg, ch);
                        word_length_mid = sat_inc(word_length_reg);
                    end
                end
                M_IDLE:  run_idle = 1'b1;
                default: run_idle = 1'b0;
            endcase

            if (run_idle && !is_space(ch))
            begin
                if (ch == betl_pkg::CH_LPAREN)
                begin
                    cand[1]       = make_token(betl_pkg::KIND_LPAREN, clamp_pos, POS_W'(1),
                                               1'b0, 1'b0);
                    cand_valid[1] = 1'b1;
                end
                else if (ch == betl_pkg::CH_RPAREN)
                begin
                    cand[1]       = make_token(betl_pkg::KIND_RPAREN, clamp_pos, POS_W'(1),
                                               1'b0, 1'b0);
                    cand_valid[1] = 1'b1;
                end
                else if (ch == betl_pkg::CH_AMP)
                begin
                    cand[1]       = make_token(betl_pkg::KIND_AND, clamp_pos, POS_W'(1),
                                               1'b0, 1'b0);
                    cand_valid[1] = 1'b1;
                end
                else if (ch == betl_pkg::CH_PIPE)
                begin
                    cand[1]       = make_token(betl_pkg::KIND_OR, clamp_pos, POS_W'(1),
                                               1'b0, 1'b0);
                    cand_valid[1] = 1'b1;
                end
                else if (ch == betl_pkg::CH_CARET)
                begin
                    cand[1]       = make_token(betl_pkg::KIND_XOR, clamp_pos, POS_W'(1),
                                               1'b0, 1'b0);
                    cand_valid[1] = 1'b1;
                end
                else if (is_word(ch))
                begin
                    mode_mid        = M_IDENT;
                    tok_begin_mid   = clamp_pos;
                    word_match_mid  = match_step(4'hF, '0, ch);
                    word_length_mid = POS_W'(1);
                end
                else if (!dialect_reg && ch == betl_pkg::CH_BANG)
                begin
                    mode_mid      = M_BANG;
                    tok_begin_mid = clamp_pos;
                end
                else if (!dialect_reg && ch == betl_pkg::CH_MINUS)
                begin
                    mode_mid      = M_MINUS;
                    tok_begin_mid = clamp_pos;
                end
                else if (!dialect_reg && ch == betl_pkg::CH_LESS)
                begin
                    mode_mid      = M_LESS;
                    tok_begin_mid = clamp_pos;
                end
                else if (!dialect_reg && ch == betl_pkg::CH_LBRACE)
                begin
                    mode_mid        = M_BRACE;
                    tok_begin_mid   = clamp_pos;
                    word_match_mid  = 4'hF;
                    word_length_mid = '0;
                end
                else if (dialect_reg && ch == betl_pkg::CH_QUOTE)
                begin
                    cand[1]       = make_token(betl_pkg::KIND_NOT, clamp_pos, POS_W'(1),
                                               1'b0, 1'b0);
                    cand_valid[1] = 1'b1;
                end
                else
                begin
                    mode_mid      = M_STICKY;
                    tok_begin_mid = clamp_pos;
                end
            end

            text_position_mid = sat_inc(text_position_reg);
        end

        if (item.end_of_text)
        begin
            case (mode_mid)
                M_BANG:
                begin
                    cand[2]       = make_token(betl_pkg::KIND_NOT, tok_begin_mid, POS_W'(1),
                                               1'b0, 1'b0);
                    cand_valid[2] = 1'b1;
                end
                M_MINUS, M_LESS:
                begin
                    cand[2]       = make_token(betl_pkg::KIND_ERROR, tok_begin_mid, POS_W'(1),
                                               1'b0, 1'b0);
                    cand_valid[2] = 1'b1;
                end
                M_IDENT:
                begin
                    cand[2]       = flush_ident(tok_begin_mid, text_position_mid,
                                                word_match_mid, word_length_mid, dialect_reg);
                    cand_valid[2] = 1'b1;
                end
                M_BRACE:
                begin
                    cand[2]       = make_token(betl_pkg::KIND_ERROR, tok_begin_mid,
                                               POS_W'(text_position_mid - POS_W'(tok_begin_mid)),
                                               1'b0, 1'b1);
                    cand_valid[2] = 1'b1;
                end
                M_STICKY:
                begin
                    cand[2]       = make_token(betl_pkg::KIND_ERROR, tok_begin_mid,
                                               POS_W'(text_position_mid - POS_W'(tok_begin_mid)),
                                               1'b0, 1'b1);
                    cand_valid[2] = 1'b1;
                    give_end      = 1'b0;
                end
                default: give_end = 1'b1;
            endcase
            cand_valid[3] = give_end;
        end

        later_valid = 1'b0;
        for (int i = NCAND - 1; i >= 0; i--)
        begin
            cand[i].last_of_run = cand_valid[i] && !later_valid;
            later_valid         = later_valid || cand_valid[i];
        end

        wr_offset = '0;
        for (int i = 0; i < NCAND; i++)
        begin
            cand_idx[i] = PTR_W'(COUNT_W'(wr_ptr_reg) + wr_offset);
            wr_offset   = wr_offset + COUNT_W'(cand_valid[i]);
        end

        mode_next          = mode_reg;
        text_position_next = text_position_reg;
        tok_begin_next     = tok_begin_reg;
        word_match_next    = word_match_reg;
        word_length_next   = word_length_reg;
        wr_ptr_next        = wr_ptr_reg;
        count_next         = count_reg;
        if (accept)
        begin
            wr_ptr_next = PTR_W'(COUNT_W'(wr_ptr_reg) + wr_offset);
            count_next  = count_reg + wr_offset;
            if (item.end_of_text)
            begin
                mode_next          = M_IDLE;
                text_position_next = '0;
                tok_begin_next     = '0;
                word_match_next    = 4'hF;
                word_length_next   = '0;
            end
            else
            begin
                mode_next          = mode_mid;
                text_position_next = text_position_mid;
                tok_begin_next     = tok_begin_mid;
                word_match_next    = word_match_mid;
                word_length_next   = word_length_mid;
            end
        end
        rd_ptr_next = pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_next - COUNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= M_IDLE;
            text_position_reg <= '0;
            tok_begin_reg     <= '0;
            word_match_reg    <= 4'hF;
            word_length_reg   <= '0;
            dialect_reg       <= 1'b0;
            rd_ptr_reg        <= '0;
            wr_ptr_reg        <= '0;
            count_reg         <= '0;
        end
        else
        begin
            mode_reg          <= mode_next;
            text_position_reg <= text_position_next;
            tok_begin_reg     <= tok_begin_next;
            word_match_reg    <= word_match_next;
            word_length_reg   <= word_length_next;
            rd_ptr_reg        <= rd_ptr_next;
            wr_ptr_reg        <= wr_ptr_next;
            count_reg         <= count_next;
            if (cfg_wr_en)
            begin
                dialect_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NCAND; i++)
        begin
            if (accept && cand_valid[i])
            begin
                queue_mem[cand_idx[i]] <= cand[i];
            end
        end
    end

    `BETL_ASSERT(a_queue_bound, count_reg <= COUNT_W'(betl_pkg::QUEUE_DEPTH), "Token queue overfilled.")
    `BETL_ASSERT(a_result_bound, !accept || ($countones(cand_valid) <= betl_pkg::MAX_RESULTS), "Beat yields too many tokens.")
    `BETL_ASSERT(a_position_bound, text_position_reg <= POS_W'(MAX_TEXT), "Text position beyond saturation.")
    `BETL_ASSERT_NEXT(a_end_resets, accept && item.end_of_text, mode_reg == M_IDLE && text_position_reg == '0, "End beat did not return the lexer to idle.")
    `BETL_ASSERT_NEXT(a_sticky_holds, mode_reg == M_STICKY && !(accept && item.end_of_text), mode_reg == M_STICKY, "Sticky error left before the end beat.")

endmodule
